FILE: sv/lspa_pkg.sv
// Shared types, widths and constants of the LED strip pulse animator.
`timescale 1ns / 1ps

package lspa_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int PULSE_SLOTS_DEF    = 8;
	localparam int LED_COUNT_DEF      = 60;
	localparam int MAX_HALF_WIDTH_DEF = 16;

	// Field widths
	localparam int NOW_W     = 32;
	localparam int ROLL_W    = 7;
	localparam int COLOUR_W  = 8;
	localparam int HW_W      = 5;
	localparam int DELAY_W   = 16;
	localparam int GAP_W     = 16;
	localparam int PIXEL_W   = 6;
	localparam int POS_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Spawn odds scale: roll*slots < SPAWN_ROLL_SPAN*(slots - count)
	localparam int SPAWN_ROLL_SPAN = 99;

	localparam logic [GAP_W-1:0] SPAWN_GAP_RST = GAP_W'(500);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_RED   = 2'd0,
		CFG_BASE_GREEN = 2'd1,
		CFG_BASE_BLUE  = 2'd2,
		CFG_SPAWN_GAP  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAWN,
		ST_MOVE,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic spawn;
		logic move;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_last;
		logic pix_last;
		logic out_room;
	} sts_t;

endpackage

FILE: sv/led_strip_pulse_animator.sv
// Top level of the LED strip pulse animator: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Item
// in        in         in_valid / in_stall  one tick: time and spawn draws
// out       out        out_valid/out_stall  one pixel colour, LED_COUNT per tick
// cfg       in         cfg_valid/cfg_ready  one register write (index, data)
//
// A tick runs in order: the accept, the spawn check, the move walk over every slot,
// then the emission of every pixel. Output stalls stretch the emit phase.
// Reset is asynchronous, active low; no clearing pass, the slots are free at once.
// The next tick is taken while the last pixel still waits in the output register.

module led_strip_pulse_animator #(
	parameter int PULSE_SLOTS    = lspa_pkg::PULSE_SLOTS_DEF,
	parameter int LED_COUNT      = lspa_pkg::LED_COUNT_DEF,
	parameter int MAX_HALF_WIDTH = lspa_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lspa_pkg::NOW_W-1:0]        now_ms,
	input  logic [lspa_pkg::ROLL_W-1:0]       spawn_roll,
	input  logic [lspa_pkg::COLOUR_W-1:0]     new_offset,
	input  logic [lspa_pkg::HW_W-1:0]         new_half_width,
	input  logic                              new_moves_up,
	input  logic [lspa_pkg::DELAY_W-1:0]      new_delay_ms,
	// pixel output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lspa_pkg::PIXEL_W-1:0]      pixel_index,
	output logic [lspa_pkg::COLOUR_W-1:0]     red,
	output logic [lspa_pkg::COLOUR_W-1:0]     green,
	output logic [lspa_pkg::COLOUR_W-1:0]     blue,
	output logic                              last_pixel,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lspa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspa_pkg::CFG_DAT_W-1:0]    cfg_data
);

	lspa_pkg::cmd_t cmd;
	lspa_pkg::sts_t sts;

	// The user must change registers only while idle; writes are always taken.
	assign cfg_ready = 1'b1;

	// Sequencer: IDLE -> SPAWN -> MOVE (per slot) -> EMIT (per pixel) -> IDLE
	lspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slots, spawn/move arithmetic, per-pixel green sum, output register
	lspa_dp #(
		.PULSE_SLOTS    (PULSE_SLOTS),
		.LED_COUNT      (LED_COUNT),
		.MAX_HALF_WIDTH (MAX_HALF_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.now_ms         (now_ms),
		.spawn_roll     (spawn_roll),
		.new_offset     (new_offset),
		.new_half_width (new_half_width),
		.new_moves_up   (new_moves_up),
		.new_delay_ms   (new_delay_ms),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.pixel_index    (pixel_index),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.last_pixel     (last_pixel)
	);

endmodule

FILE: sv/lspa_ctrl.sv
// Tick sequencer: spawn check, slot walk, pixel emission.
`timescale 1ns / 1ps

module lspa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lspa_pkg::sts_t      sts,
	output lspa_pkg::cmd_t      cmd
);

	lspa_pkg::state_t state_q;
	lspa_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lspa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			lspa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = lspa_pkg::ST_SPAWN;
				end
			end
			lspa_pkg::ST_SPAWN: begin
				cmd.spawn = 1'b1;
				state_nxt = lspa_pkg::ST_MOVE;
			end
			lspa_pkg::ST_MOVE: begin
				cmd.move = 1'b1;
				if (sts.slot_last) begin
					state_nxt = lspa_pkg::ST_EMIT;
				end
			end
			lspa_pkg::ST_EMIT: begin
				cmd.emit = sts.out_room;
				if (sts.out_room && sts.pix_last) begin
					state_nxt = lspa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lspa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/lspa_dp.sv
// Datapath: tick latch, config registers, pulse slots, pixel colour and output register.
`timescale 1ns / 1ps

module lspa_dp #(
	parameter int PULSE_SLOTS    = lspa_pkg::PULSE_SLOTS_DEF,
	parameter int LED_COUNT      = lspa_pkg::LED_COUNT_DEF,
	parameter int MAX_HALF_WIDTH = lspa_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lspa_pkg::cmd_t                    cmd,
	output lspa_pkg::sts_t                    sts,
	// tick fields
	input  logic [lspa_pkg::NOW_W-1:0]        now_ms,
	input  logic [lspa_pkg::ROLL_W-1:0]       spawn_roll,
	input  logic [lspa_pkg::COLOUR_W-1:0]     new_offset,
	input  logic [lspa_pkg::HW_W-1:0]         new_half_width,
	input  logic                              new_moves_up,
	input  logic [lspa_pkg::DELAY_W-1:0]      new_delay_ms,
	// config writes
	input  logic                              cfg_we,
	input  logic [lspa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspa_pkg::CFG_DAT_W-1:0]    cfg_data,
	// pixel output
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [lspa_pkg::PIXEL_W-1:0]      pixel_index,
	output logic [lspa_pkg::COLOUR_W-1:0]     red,
	output logic [lspa_pkg::COLOUR_W-1:0]     green,
	output logic [lspa_pkg::COLOUR_W-1:0]     blue,
	output logic                              last_pixel
);

	localparam int SLOT_W = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(PULSE_SLOTS + 1);
	localparam int PIX_W  = $clog2(LED_COUNT);
	localparam int MUL_W  = lspa_pkg::ROLL_W + CNT_W;
	localparam int SUM_W  = lspa_pkg::COLOUR_W + CNT_W;
	localparam int POS_W  = lspa_pkg::POS_W;
	localparam int HW_W   = lspa_pkg::HW_W;
	localparam int NOW_W  = lspa_pkg::NOW_W;

	// config registers
	logic [lspa_pkg::COLOUR_W-1:0] base_red_q, base_green_q, base_blue_q;
	logic [lspa_pkg::GAP_W-1:0]    spawn_gap_q;

	// latched tick
	logic [NOW_W-1:0]               now_q;
	logic [lspa_pkg::ROLL_W-1:0]    roll_q;
	logic [lspa_pkg::COLOUR_W-1:0]  offset_q;
	logic [HW_W-1:0]                hw_q;
	logic                           up_q;
	logic [lspa_pkg::DELAY_W-1:0]   delay_q;

	// slots
	logic                           slot_active_q   [PULSE_SLOTS];
	logic                           slot_up_q       [PULSE_SLOTS];
	logic signed [POS_W-1:0]        slot_first_q    [PULSE_SLOTS];
	logic signed [POS_W-1:0]        slot_last_q     [PULSE_SLOTS];
	logic [lspa_pkg::COLOUR_W-1:0]  slot_offset_q   [PULSE_SLOTS];
	logic [lspa_pkg::DELAY_W-1:0]   slot_delay_q    [PULSE_SLOTS];
	logic [NOW_W-1:0]               slot_lmove_q    [PULSE_SLOTS];
	logic [CNT_W-1:0]               active_cnt_q;
	logic [NOW_W-1:0]               last_spawn_q;

	// walk counters
	logic [SLOT_W-1:0]              slot_idx_q;
	logic [PIX_W-1:0]               pix_q;

	// output register
	logic                           out_valid_q;
	logic [lspa_pkg::PIXEL_W-1:0]   pixel_index_q;
	logic [lspa_pkg::COLOUR_W-1:0]  red_q, green_q, blue_q;
	logic                           last_pixel_q;

	// spawn decision
	logic                           gap_ok, odds_ok, spawn_try, spawn_hit, free_ok;
	logic [SLOT_W-1:0]              free_idx;
	logic [MUL_W-1:0]               roll_prod, quota;
	logic [HW_W-1:0]                hw_clamp;
	logic [HW_W:0]                  width2;
	logic signed [POS_W-1:0]        spawn_first, spawn_last;

	// move decision for the slot being visited
	logic                           mv_due, mv_retire;
	logic signed [POS_W-1:0]        mv_first, mv_last;

	// pixel colour
	logic signed [POS_W-1:0]        pix_pos;
	logic [SUM_W-1:0]               g_sum;
	logic [lspa_pkg::COLOUR_W-1:0]  g_sat;
	logic                           pix_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_red_q   <= '0;
			base_green_q <= '0;
			base_blue_q  <= '0;
			spawn_gap_q  <= lspa_pkg::SPAWN_GAP_RST;
		end else if (cfg_we) begin
			unique case (lspa_pkg::cfg_idx_t'(cfg_index))
				lspa_pkg::CFG_BASE_RED:   base_red_q   <= cfg_data[lspa_pkg::COLOUR_W-1:0];
				lspa_pkg::CFG_BASE_GREEN: base_green_q <= cfg_data[lspa_pkg::COLOUR_W-1:0];
				lspa_pkg::CFG_BASE_BLUE:  base_blue_q  <= cfg_data[lspa_pkg::COLOUR_W-1:0];
				lspa_pkg::CFG_SPAWN_GAP:  spawn_gap_q  <= cfg_data[lspa_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= now_ms;
			roll_q   <= spawn_roll;
			offset_q <= new_offset;
			hw_q     <= new_half_width;
			up_q     <= new_moves_up;
			delay_q  <= new_delay_ms;
		end
	end

	// spawn
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int k = PULSE_SLOTS - 1; k >= 0; k--) begin
			if (!slot_active_q[k]) begin
				free_ok  = 1'b1;
				free_idx = SLOT_W'(k);
			end
		end
	end

	assign gap_ok    = (now_q - last_spawn_q) > NOW_W'(spawn_gap_q);
	assign spawn_try = gap_ok && (active_cnt_q < CNT_W'(PULSE_SLOTS));
	assign roll_prod = MUL_W'(roll_q) * MUL_W'(PULSE_SLOTS);
	assign quota     = MUL_W'(lspa_pkg::SPAWN_ROLL_SPAN)
		* (MUL_W'(PULSE_SLOTS) - MUL_W'(active_cnt_q));
	assign odds_ok   = roll_prod < quota;
	assign spawn_hit = cmd.spawn && spawn_try && odds_ok && free_ok;

	always_comb begin
		if (hw_q == '0) begin
			hw_clamp = HW_W'(1);
		end else if (hw_q > HW_W'(MAX_HALF_WIDTH)) begin
			hw_clamp = HW_W'(MAX_HALF_WIDTH);
		end else begin
			hw_clamp = hw_q;
		end
	end

	assign width2      = {hw_clamp, 1'b0};
	assign spawn_first = up_q ? (POS_W'(1) - POS_W'(width2)) : POS_W'(LED_COUNT - 1);
	assign spawn_last  = up_q ? '0 : (POS_W'(LED_COUNT - 2) + POS_W'(width2));

	// move, one slot per cycle
	assign mv_due   = cmd.move && slot_active_q[slot_idx_q]
		&& ((now_q - slot_lmove_q[slot_idx_q]) > NOW_W'(slot_delay_q[slot_idx_q]));
	assign mv_first = slot_up_q[slot_idx_q] ? slot_first_q[slot_idx_q] + POS_W'(1)
		: slot_first_q[slot_idx_q] - POS_W'(1);
	assign mv_last  = slot_up_q[slot_idx_q] ? slot_last_q[slot_idx_q] + POS_W'(1)
		: slot_last_q[slot_idx_q] - POS_W'(1);
	assign mv_retire = slot_up_q[slot_idx_q] ? (mv_first >= $signed(POS_W'(LED_COUNT)))
		: (mv_last <= $signed(POS_W'(0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PULSE_SLOTS; k++) begin
				slot_active_q[k] <= 1'b0;
			end
			active_cnt_q <= '0;
			last_spawn_q <= '0;
		end else begin
			if (cmd.spawn && spawn_try) begin
				last_spawn_q <= now_q;
			end
			if (spawn_hit) begin
				slot_active_q[free_idx] <= 1'b1;
				active_cnt_q            <= active_cnt_q + CNT_W'(1);
			end
			if (mv_due && mv_retire) begin
				slot_active_q[slot_idx_q] <= 1'b0;
				if (active_cnt_q != '0) begin
					active_cnt_q <= active_cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PULSE_SLOTS; k++) begin
			if (spawn_hit && free_idx == SLOT_W'(k)) begin
				slot_up_q[k]     <= up_q;
				slot_first_q[k]  <= spawn_first;
				slot_last_q[k]   <= spawn_last;
				slot_offset_q[k] <= offset_q;
				slot_delay_q[k]  <= delay_q;
				slot_lmove_q[k]  <= now_q;
			end else if (mv_due && slot_idx_q == SLOT_W'(k)) begin
				slot_first_q[k]  <= mv_first;
				slot_last_q[k]   <= mv_last;
				slot_lmove_q[k]  <= now_q;
			end
		end
	end

	// pixel colour: every slot lane checks coverage, offsets summed then clamped
	assign pix_pos  = $signed(POS_W'(pix_q));
	assign pix_last = (pix_q == PIX_W'(LED_COUNT - 1));

	always_comb begin
		g_sum = SUM_W'(base_green_q);
		for (int k = 0; k < PULSE_SLOTS; k++) begin
			if (slot_active_q[k] && pix_pos >= slot_first_q[k] && pix_pos <= slot_last_q[k]) begin
				g_sum = g_sum + SUM_W'(slot_offset_q[k]);
			end
		end
		g_sat = (g_sum > SUM_W'({lspa_pkg::COLOUR_W{1'b1}})) ? {lspa_pkg::COLOUR_W{1'b1}}
			: g_sum[lspa_pkg::COLOUR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_idx_q  <= '0;
			pix_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				slot_idx_q <= '0;
				pix_q      <= '0;
			end
			if (cmd.move) begin
				slot_idx_q <= slot_idx_q + SLOT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				pix_q       <= pix_q + PIX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_index_q <= lspa_pkg::PIXEL_W'(pix_q);
			red_q         <= base_red_q;
			green_q       <= g_sat;
			blue_q        <= base_blue_q;
			last_pixel_q  <= pix_last;
		end
	end

	assign sts.slot_last = (slot_idx_q == SLOT_W'(PULSE_SLOTS - 1));
	assign sts.pix_last  = pix_last;
	assign sts.out_room  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign last_pixel  = last_pixel_q;

endmodule

FILE: sv/lspa_chk.sv
// Port-level checker for the LED strip pulse animator, bound to the top level.
`timescale 1ns / 1ps

module lspa_chk #(
	parameter int LED_COUNT = lspa_pkg::LED_COUNT_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [lspa_pkg::PIXEL_W-1:0]      pixel_index,
	input logic                              last_pixel
);

	// a tick is worked on alone: stall follows every accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("tick accepted while previous tick still in work");

	// no new tick may enter mid-frame
	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_pixel |-> in_stall)
		else $error("input open before frame finished");

	// frame end marker sits on the final LED
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_index == lspa_pkg::PIXEL_W'(LED_COUNT - 1))
		else $error("last pixel flag on wrong index");

	// stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_index))
		else $error("stalled pixel item changed");

endmodule

bind led_strip_pulse_animator lspa_chk #(.LED_COUNT(LED_COUNT)) u_lspa_chk (.*);
